@@ rtl/escape_sequence_to_utf8_decoder_assert.svh @@
// Assertion macros used by the escape decoder datapath
`ifndef ESCAPE_SEQUENCE_TO_UTF8_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_TO_UTF8_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ESC_U8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ESC_U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/esc_u8_pkg.sv @@
// Types, constants and helper functions for the escape decoder
`timescale 1ns / 1ps
`default_nettype none

package esc_u8_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam int unsigned HOLD_DEPTH = 5;

  localparam logic [2:0] HEX2_DONE_CNT = 3'd3;
  localparam logic [2:0] HEX4_DONE_CNT = 3'd5;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX2,
    MODE_HEX4
  } mode_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic emit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic none;
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } utf8_t;

  function automatic hex_t hex_nibble(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t r;
    r.b1 = 8'h00;
    r.b2 = 8'h00;
    if (cp <= 16'h007F) begin
      r.len = 2'd1;
      r.b0  = cp[7:0];
    end else if (cp <= 16'h07FF) begin
      r.len = 2'd2;
      r.b0  = 8'hC0 | {3'b000, cp[10:6]};
      r.b1  = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      r.len = 2'd3;
      r.b0  = 8'hE0 | {4'b0000, cp[15:12]};
      r.b1  = 8'h80 | {2'b00, cp[11:6]};
      r.b2  = 8'h80 | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/esc_u8_ctrl.sv @@
// Sequencing state machine for the escape decoder
`timescale 1ns / 1ps
`default_nettype none

module esc_u8_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire esc_u8_pkg::sts_t sts_i,
  output esc_u8_pkg::cmd_t      cmd_o
);

  esc_u8_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esc_u8_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      esc_u8_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = esc_u8_pkg::ST_EMIT;
        end
      end
      esc_u8_pkg::ST_EMIT: begin
        if (sts_i.none) begin
          cmd_o.commit = 1'b1;
          state_d      = esc_u8_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            cmd_o.commit = 1'b1;
            state_d      = esc_u8_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = esc_u8_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/esc_u8_dp.sv @@
// Datapath: held bytes, hex accumulator, byte selection and output register
`timescale 1ns / 1ps
`default_nettype none
`include "escape_sequence_to_utf8_decoder_assert.svh"

module esc_u8_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             in_end_i,
  input  wire esc_u8_pkg::cmd_t cmd_i,
  output esc_u8_pkg::sts_t      sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o,
  output logic                  string_done_o
);

  logic [7:0]          byte_q;
  logic                end_q;
  esc_u8_pkg::mode_e   mode_q, mode_d;
  logic [7:0]          held_q [esc_u8_pkg::HOLD_DEPTH];
  logic [2:0]          held_cnt_q, held_cnt_d;
  logic [15:0]         accum_q, accum_d;
  logic [2:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  logic                out_done_q;

  esc_u8_pkg::hex_t    hex;
  esc_u8_pkg::utf8_t   enc;
  logic [15:0]         accum_next;
  logic                is_bs;
  logic                is_xu;
  logic                in_hex;
  logic                brk;
  logic                done_x;
  logic                done_u;
  logic                hold_b;
  logic [2:0]          na;
  logic [1:0]          xn;
  logic [2:0]          total;
  logic [2:0]          rel;
  logic [7:0]          x0, x1, x2;
  logic [7:0]          x_sel;
  logic [7:0]          byte_sel;
  logic                held_wr;
  logic [2:0]          held_wr_idx;

  always_comb begin
    hex        = esc_u8_pkg::hex_nibble(byte_q);
    accum_next = {accum_q[11:0], hex.val};
    enc        = esc_u8_pkg::utf8_encode(accum_next);
    is_bs      = (byte_q == esc_u8_pkg::CHAR_BACKSLASH);
    is_xu      = (byte_q == esc_u8_pkg::CHAR_X) || (byte_q == esc_u8_pkg::CHAR_U);
    in_hex     = (mode_q == esc_u8_pkg::MODE_HEX2) || (mode_q == esc_u8_pkg::MODE_HEX4);
    brk        = ((mode_q == esc_u8_pkg::MODE_ESC) && !is_xu) || (in_hex && !hex.ok);
    done_x     = (mode_q == esc_u8_pkg::MODE_HEX2) && hex.ok
                 && (held_cnt_q >= esc_u8_pkg::HEX2_DONE_CNT);
    done_u     = (mode_q == esc_u8_pkg::MODE_HEX4) && hex.ok
                 && (held_cnt_q >= esc_u8_pkg::HEX4_DONE_CNT);
    hold_b     = ((mode_q == esc_u8_pkg::MODE_PLAIN) && is_bs)
                 || ((mode_q == esc_u8_pkg::MODE_ESC) && is_xu)
                 || (in_hex && hex.ok && !done_x && !done_u);

    na = (brk || (end_q && hold_b)) ? held_cnt_q : 3'd0;

    if (done_x) begin
      xn = 2'd1;
    end else if (done_u) begin
      xn = enc.len;
    end else if ((hold_b || (brk && is_bs)) && !end_q) begin
      xn = 2'd0;
    end else begin
      xn = 2'd1;
    end

    x0 = done_x ? accum_next[7:0] : (done_u ? enc.b0 : byte_q);
    x1 = enc.b1;
    x2 = enc.b2;

    total = 3'(na + {1'b0, xn});
    rel   = 3'(idx_q - na);
    case (rel[1:0])
      2'd0:    x_sel = x0;
      2'd1:    x_sel = x1;
      default: x_sel = x2;
    endcase
    byte_sel = (idx_q < na) ? held_q[idx_q] : x_sel;

    sts_o.none     = (total == 3'd0);
    sts_o.last     = (idx_q == 3'(total - 3'd1));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // state update, applied once all beats of the item are out
  always_comb begin
    mode_d      = mode_q;
    held_cnt_d  = held_cnt_q;
    accum_d     = accum_q;
    held_wr     = 1'b0;
    held_wr_idx = held_cnt_q;
    if (cmd_i.commit) begin
      if (end_q || done_x || done_u) begin
        mode_d     = esc_u8_pkg::MODE_PLAIN;
        held_cnt_d = 3'd0;
        accum_d    = 16'h0000;
      end else if (brk) begin
        accum_d = 16'h0000;
        if (is_bs) begin
          mode_d      = esc_u8_pkg::MODE_ESC;
          held_cnt_d  = 3'd1;
          held_wr     = 1'b1;
          held_wr_idx = 3'd0;
        end else begin
          mode_d     = esc_u8_pkg::MODE_PLAIN;
          held_cnt_d = 3'd0;
        end
      end else if (hold_b) begin
        held_wr    = 1'b1;
        held_cnt_d = 3'(held_cnt_q + 3'd1);
        case (mode_q)
          esc_u8_pkg::MODE_PLAIN: mode_d = esc_u8_pkg::MODE_ESC;
          esc_u8_pkg::MODE_ESC: begin
            mode_d  = (byte_q == esc_u8_pkg::CHAR_X) ? esc_u8_pkg::MODE_HEX2
                                                     : esc_u8_pkg::MODE_HEX4;
            accum_d = 16'h0000;
          end
          default: accum_d = accum_next;
        endcase
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = 3'd0;
    end else if (cmd_i.emit) begin
      idx_d = 3'(idx_q + 3'd1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= esc_u8_pkg::MODE_PLAIN;
      held_cnt_q  <= 3'd0;
      accum_q     <= 16'h0000;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      held_cnt_q  <= held_cnt_d;
      accum_q     <= accum_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= in_byte_i;
      end_q  <= in_end_i;
    end
    if (held_wr) begin
      held_q[held_wr_idx] <= byte_q;
    end
    if (cmd_i.emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= sts_o.last;
      out_done_q <= sts_o.last && end_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = out_last_q;
  assign string_done_o = out_done_q;

  `ESC_U8_ASSERT_NOW(a_emit_free, cmd_i.emit, !out_valid_q || out_ready_i, "beat overwritten")
  `ESC_U8_ASSERT_NOW(a_plain_empty, mode_q == esc_u8_pkg::MODE_PLAIN, held_cnt_q == 3'd0, "held")
  `ESC_U8_ASSERT_NOW(a_esc_one, mode_q == esc_u8_pkg::MODE_ESC, held_cnt_q == 3'd1, "esc count")
  `ESC_U8_ASSERT_NEXT(a_last_out, cmd_i.emit && sts_o.last, out_valid_q && out_last_q, "no last")

endmodule

`default_nettype wire

@@ rtl/escape_sequence_to_utf8_decoder.sv @@
// Top level of the escape-sequence to UTF-8 decoder
//
//   channel  dir  handshake                fields
//   in       in   in_valid_i / in_ready_o  in_byte_i, in_end_i
//   out      out  out_valid_o / out_ready_i out_byte_o, run_last_o, string_done_o
//
// An item is accepted in ST_IDLE; ST_EMIT then emits its beats, possibly none, one per cycle while the output is free,
// tracked by the emission counter in the datapath.
// The output register lets the last beat of an item wait while the next item is taken.
// A low out_ready_i holds emission; no beat is dropped.
// Reset clears mode, held count and accumulator at once; held bytes need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_to_utf8_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_done_o
);

  esc_u8_pkg::cmd_t cmd;
  esc_u8_pkg::sts_t sts;

  esc_u8_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  esc_u8_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .in_end_i      (in_end_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule

`default_nettype wire
